// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker file fdtd_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, muted while reset is high.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property at every rising edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- src/fdtd_pkg.sv -----
// ----------------------------------------------------------------------------
// fdtd_pkg
// Shared sizes, codes, types and helper functions of the FDTD grid engine.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int MAX_NX   = 64;
  localparam int MAX_NY   = 64;
  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int COEF_W   = 16;
  localparam int IDX_W    = 7;
  localparam int FUNC_W   = 2;
  localparam int SEL_W    = 2;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam int P_DEPTH  = MAX_NX * MAX_NY;
  localparam int U_STRIDE = MAX_NX + 1;
  localparam int U_DEPTH  = U_STRIDE * MAX_NY;
  localparam int V_DEPTH  = MAX_NX * (MAX_NY + 1);
  localparam int P_AW     = $clog2(P_DEPTH);
  localparam int U_AW     = $clog2(U_DEPTH);
  localparam int V_AW     = $clog2(V_DEPTH);

  localparam int CLR_DEPTH = (U_DEPTH > V_DEPTH) ? U_DEPTH : V_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam int ZB_N      = (MAX_NX > MAX_NY) ? MAX_NX : MAX_NY;
  localparam int ZB_W      = $clog2(ZB_N);

  localparam int TERM_W   = VAL_W + 1;
  localparam int PROD_W   = VAL_W + COEF_W + 1;
  localparam int SUM_W    = VAL_W + 2;
  localparam int ROUND    = 1 << (FRAC_W - 1);

  localparam logic [IDX_W-1:0]  CELLS_RST = IDX_W'(64);
  localparam logic [COEF_W-1:0] COEF_RST  = COEF_W'(32768);

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_STEP  = 2'd2,
    FN_ZERO  = 2'd3
  } func_t;

  localparam logic [SEL_W-1:0] SEL_P = 2'd0;
  localparam logic [SEL_W-1:0] SEL_U = 2'd1;
  localparam logic [SEL_W-1:0] SEL_V = 2'd2;

  localparam logic [CFG_IW-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IW-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COEF_X  = 2'd2;
  localparam logic [CFG_IW-1:0] REG_COEF_Y  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDW,
    ST_RD,
    ST_DIF,
    ST_MUL,
    ST_AD1,
    ST_AD2,
    ST_ZB,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_P,
    PH_U,
    PH_V
  } phase_t;

  typedef struct packed {
    logic clr;
    logic dif_en;
    logic mul_en;
    logic ad1_en;
    logic ad2_en;
    logic two_terms;
  } alu_ctl_t;

  function automatic logic sat_hit(input logic signed [SUM_W-1:0] x);
    return !((&x[SUM_W-1:VAL_W-1]) || !(|x[SUM_W-1:VAL_W-1]));
  endfunction

  function automatic logic [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (!sat_hit(x)) r = x[VAL_W-1:0];
    else if (x[SUM_W-1]) r = {1'b1, {(VAL_W-1){1'b0}}};
    else r = {1'b0, {(VAL_W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] eff_cnt(input logic [IDX_W-1:0] v,
                                               input int unsigned lim);
    logic [IDX_W-1:0] r;
    if (v == '0) r = IDX_W'(1);
    else if (32'(v) > lim) r = IDX_W'(lim);
    else r = v;
    return r;
  endfunction

  function automatic logic [P_AW-1:0] p_addr(input logic [IDX_W-1:0] c,
                                             input logic [IDX_W-1:0] r);
    return P_AW'(32'(r) * MAX_NX + 32'(c));
  endfunction

  function automatic logic [U_AW-1:0] u_addr(input logic [IDX_W-1:0] c,
                                             input logic [IDX_W-1:0] r);
    return U_AW'(32'(r) * U_STRIDE + 32'(c));
  endfunction

  function automatic logic [V_AW-1:0] v_addr(input logic [IDX_W-1:0] c,
                                             input logic [IDX_W-1:0] r);
    return V_AW'(32'(r) * MAX_NX + 32'(c));
  endfunction

endpackage

// ----- src/fdtd_if.sv -----
// ----------------------------------------------------------------------------
// fdtd_if
// Request and response channels of the FDTD grid engine.
// ----------------------------------------------------------------------------
interface fdtd_req_if
  import fdtd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [SEL_W-1:0]        array_sel;
  logic [IDX_W-1:0]        col;
  logic [IDX_W-1:0]        row;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, func, array_sel, col, row, write_value, input ready);
  modport sink   (input valid, func, array_sel, col, row, write_value, output ready);
endinterface

interface fdtd_rsp_if
  import fdtd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic                    saturated;
  logic                    index_error;

  modport source (output valid, read_value, saturated, index_error, input ready);
  modport sink   (input valid, read_value, saturated, index_error, output ready);
endinterface

// ----- src/fdtd_ram.sv -----
// ----------------------------------------------------------------------------
// fdtd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/fdtd_alu.sv -----
// ----------------------------------------------------------------------------
// fdtd_alu
// Cell update datapath: saturated differences, scaling by coefficients with
// round half up, and two saturated sums, all registered but the second sum.
// ----------------------------------------------------------------------------
module fdtd_alu
  import fdtd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  alu_ctl_t                ctl,
  input  logic signed [VAL_W-1:0] a1,
  input  logic signed [VAL_W-1:0] b1,
  input  logic signed [VAL_W-1:0] a2,
  input  logic signed [VAL_W-1:0] b2,
  input  logic signed [VAL_W-1:0] old,
  input  logic [COEF_W-1:0]       coef1,
  input  logic [COEF_W-1:0]       coef2,
  output logic signed [VAL_W-1:0] result,
  output logic                    clipped
);

  logic signed [SUM_W-1:0]  d1_full, d2_full, s1_full, s2_full;
  logic signed [VAL_W-1:0]  d1, d2, old_r, s1;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [TERM_W-1:0] t1, t2;
  logic                     hit;

  assign d1_full = SUM_W'(a1) - SUM_W'(b1);
  assign d2_full = SUM_W'(a2) - SUM_W'(b2);
  assign p1      = PROD_W'(d1) * PROD_W'($signed({1'b0, coef1}));
  assign p2      = PROD_W'(d2) * PROD_W'($signed({1'b0, coef2}));
  assign s1_full = SUM_W'(old_r) + SUM_W'(t1);
  assign s2_full = SUM_W'(s1) + SUM_W'(t2);
  assign result  = sat_val(s2_full);

  // Second difference only counts for a pressure update.
  assign hit = (ctl.dif_en && (sat_hit(d1_full) || (ctl.two_terms && sat_hit(d2_full))))
            || (ctl.ad1_en && sat_hit(s1_full))
            || (ctl.ad2_en && sat_hit(s2_full));

  always_ff @(posedge clk) begin
    if (ctl.dif_en) begin
      d1    <= sat_val(d1_full);
      d2    <= ctl.two_terms ? sat_val(d2_full) : '0;
      old_r <= old;
    end
    if (ctl.mul_en) begin
      t1 <= TERM_W'((p1 + PROD_W'(ROUND)) >>> FRAC_W);
      t2 <= TERM_W'((p2 + PROD_W'(ROUND)) >>> FRAC_W);
    end
    if (ctl.ad1_en) begin
      s1 <= sat_val(s1_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      clipped <= 1'b0;
    end else if (hit) begin
      clipped <= 1'b1;
    end
  end

endmodule

// ----- src/acoustic_fdtd_leapfrog_step.sv -----
// ----------------------------------------------------------------------------
// acoustic_fdtd_leapfrog_step
// Staggered 2D acoustic grid with cell access and leapfrog time steps.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer: write a cell, read a cell, run
//   one leapfrog step, or zero the boundary velocities. rsp returns exactly
//   one result per request, in order. cfg_we/cfg_index/cfg_data write the
//   grid size and the two coefficients; write them only while idle.
// Sequencing: a write goes straight to the finish state, a read in range
//   passes a read-wait state first, boundary zeroing walks both edges for
//   each index below 64, and a time step updates 3*nx*ny - nx - ny cells in turn.
//   Each cell update is a read / difference / multiply / add / add-and-write
//   pass over the memories; one cell is in flight at a time, so the step
//   length is set by the RD, DIF, MUL, AD1, AD2 cell loop around the RAM ports.
//   One request is worked at a time; the next is taken once back in idle.
// Reset: rst clears control state, then a clearing pass zeroes all three
//   grid memories; req.ready stays low meanwhile.
// Stall: a finished result sits in the response register; a new request is
//   still taken, and the block holds its next result until rsp drains.
// ----------------------------------------------------------------------------
module acoustic_fdtd_leapfrog_step
  import fdtd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  fdtd_req_if.sink          req,
  fdtd_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  // Configuration registers
  logic [IDX_W-1:0]  cells_x, cells_y;
  logic [COEF_W-1:0] coef_x, coef_y;
  logic [IDX_W-1:0]  nx, ny;

  // Sequencer state
  state_t           state, state_next;
  phase_t           phase;
  logic [IDX_W-1:0] i, j;
  logic [ZB_W-1:0]  zb_k;
  logic             zb_s;
  logic [CLR_W-1:0] clr_cnt;
  logic [FUNC_W-1:0] func_r;
  logic [SEL_W-1:0]  sel_r;

  // Result holding and output register
  logic [VAL_W-1:0] res_rv;
  logic             res_err;
  logic             out_valid;
  logic [VAL_W-1:0] out_rv;
  logic             out_sat, out_err;

  // Memory ports
  logic             p_we, u_we, v_we;
  logic [P_AW-1:0]  p_wa, p_ra, p_rb;
  logic [U_AW-1:0]  u_wa, u_ra, u_rb;
  logic [V_AW-1:0]  v_wa, v_ra, v_rb;
  logic [VAL_W-1:0] p_wd, u_wd, v_wd;
  logic [VAL_W-1:0] p_qa, p_qb, u_qa, u_qb, v_qa, v_qb;

  // Datapath
  alu_ctl_t          alu_ctl;
  logic [VAL_W-1:0]  alu_a1, alu_b1, alu_a2, alu_b2, alu_old, alu_res;
  logic [COEF_W-1:0] alu_c1, alu_c2;
  logic              alu_clip;

  logic acc, idx_ok, last_i, last_j, step_done, out_free, clr_last, zb_last;

  assign nx = eff_cnt(cells_x, MAX_NX);
  assign ny = eff_cnt(cells_y, MAX_NY);

  assign acc      = req.valid && req.ready;
  assign last_i   = (i == nx - IDX_W'(1));
  assign last_j   = (j == ny - IDX_W'(1));
  assign out_free = !out_valid || rsp.ready;
  assign clr_last = (clr_cnt == CLR_W'(CLR_DEPTH - 1));
  assign zb_last  = (zb_k == ZB_W'(ZB_N - 1)) && zb_s;

  // The step ends after the last phase that has any cells.
  assign step_done = last_i && last_j &&
                     ((phase == PH_V) ||
                      (phase == PH_U && ny == IDX_W'(1)) ||
                      (phase == PH_P && nx == IDX_W'(1) && ny == IDX_W'(1)));

  // Bounds check of the addressed cell against the selected grid
  always_comb begin
    unique case (req.array_sel)
      SEL_P:   idx_ok = (req.col < nx) && (req.row < ny);
      SEL_U:   idx_ok = (req.col <= nx) && (req.row < ny);
      SEL_V:   idx_ok = (req.col < nx) && (req.row <= ny);
      default: idx_ok = 1'b0;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= CELLS_RST;
      cells_y <= CELLS_RST;
      coef_x  <= COEF_RST;
      coef_y  <= COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS_X: cells_x <= cfg_data[IDX_W-1:0];
        REG_CELLS_Y: cells_y <= cfg_data[IDX_W-1:0];
        REG_COEF_X:  coef_x  <= cfg_data;
        REG_COEF_Y:  coef_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (acc) begin
          unique case (func_t'(req.func))
            FN_WRITE: state_next = ST_FIN;
            FN_READ:  state_next = idx_ok ? ST_RDW : ST_FIN;
            FN_STEP:  state_next = ST_RD;
            FN_ZERO:  state_next = ST_ZB;
            default:  state_next = ST_FIN;
          endcase
        end
      end
      ST_RDW:  state_next = ST_FIN;
      ST_RD:   state_next = ST_DIF;
      ST_DIF:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_AD1;
      ST_AD1:  state_next = ST_AD2;
      ST_AD2:  state_next = step_done ? ST_FIN : ST_RD;
      ST_ZB:   if (zb_last) state_next = ST_FIN;
      ST_FIN:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs: request ready and datapath stage enables
  always_comb begin
    req.ready         = 1'b0;
    alu_ctl           = '0;
    alu_ctl.two_terms = (phase == PH_P);
    unique case (state)
      ST_IDLE: begin
        req.ready   = 1'b1;
        alu_ctl.clr = 1'b1;
      end
      ST_DIF:  alu_ctl.dif_en = 1'b1;
      ST_MUL:  alu_ctl.mul_en = 1'b1;
      ST_AD1:  alu_ctl.ad1_en = 1'b1;
      ST_AD2:  alu_ctl.ad2_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      phase   <= PH_P;
      i       <= '0;
      j       <= '0;
      zb_k    <= '0;
      zb_s    <= 1'b0;
      func_r  <= FN_WRITE;
      sel_r   <= SEL_P;
    end else begin
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (acc) begin
        func_r <= req.func;
        sel_r  <= req.array_sel;
        phase  <= PH_P;
        i      <= '0;
        j      <= '0;
        zb_k   <= '0;
        zb_s   <= 1'b0;
      end
      if (state == ST_AD2 && !step_done) begin
        if (!last_i) begin
          i <= i + IDX_W'(1);
        end else if (!last_j) begin
          i <= (phase == PH_U) ? IDX_W'(1) : '0;
          j <= j + IDX_W'(1);
        end else begin
          // Advance to the next phase, skipping an empty x-velocity phase
          if (phase == PH_P && nx != IDX_W'(1)) begin
            phase <= PH_U;
            i     <= IDX_W'(1);
            j     <= '0;
          end else begin
            phase <= PH_V;
            i     <= '0;
            j     <= IDX_W'(1);
          end
        end
      end
      if (state == ST_ZB) begin
        zb_s <= !zb_s;
        if (zb_s) begin
          zb_k <= zb_k + ZB_W'(1);
        end
      end
    end
  end

  // Read addresses: the request's cell while idle, the stencil otherwise
  always_comb begin
    p_ra = p_addr(i, j);
    p_rb = (phase == PH_U) ? p_addr(i - IDX_W'(1), j) : p_addr(i, j - IDX_W'(1));
    u_ra = (phase == PH_P) ? u_addr(i + IDX_W'(1), j) : u_addr(i, j);
    u_rb = u_addr(i, j);
    v_ra = (phase == PH_P) ? v_addr(i, j + IDX_W'(1)) : v_addr(i, j);
    v_rb = v_addr(i, j);
    if (state == ST_IDLE) begin
      p_ra = p_addr(req.col, req.row);
      u_ra = u_addr(req.col, req.row);
      v_ra = v_addr(req.col, req.row);
    end
  end

  // Write ports: clearing pass, cell write, cell update, boundary zeroing
  always_comb begin
    p_we = 1'b0;
    u_we = 1'b0;
    v_we = 1'b0;
    p_wa = p_addr(i, j);
    u_wa = u_addr(i, j);
    v_wa = v_addr(i, j);
    p_wd = alu_res;
    u_wd = alu_res;
    v_wd = alu_res;
    case (state)
      ST_CLEAR: begin
        p_we = (32'(clr_cnt) < P_DEPTH);
        u_we = (32'(clr_cnt) < U_DEPTH);
        v_we = (32'(clr_cnt) < V_DEPTH);
        p_wa = P_AW'(clr_cnt);
        u_wa = U_AW'(clr_cnt);
        v_wa = V_AW'(clr_cnt);
        p_wd = '0;
        u_wd = '0;
        v_wd = '0;
      end
      ST_IDLE: begin
        p_wa = p_addr(req.col, req.row);
        u_wa = u_addr(req.col, req.row);
        v_wa = v_addr(req.col, req.row);
        p_wd = req.write_value;
        u_wd = req.write_value;
        v_wd = req.write_value;
        if (acc && func_t'(req.func) == FN_WRITE && idx_ok) begin
          p_we = (req.array_sel == SEL_P);
          u_we = (req.array_sel == SEL_U);
          v_we = (req.array_sel == SEL_V);
        end
      end
      ST_AD2: begin
        p_we = (phase == PH_P);
        u_we = (phase == PH_U);
        v_we = (phase == PH_V);
      end
      ST_ZB: begin
        v_we = (IDX_W'(zb_k) < nx);
        u_we = (IDX_W'(zb_k) < ny);
        v_wa = v_addr(IDX_W'(zb_k), zb_s ? ny : '0);
        u_wa = u_addr(zb_s ? nx : '0, IDX_W'(zb_k));
        u_wd = '0;
        v_wd = '0;
      end
      default: ;
    endcase
  end

  // Operand selection per phase
  always_comb begin
    alu_a2 = v_qa;
    alu_b2 = v_qb;
    alu_c2 = coef_y;
    alu_a1 = p_qa;
    alu_b1 = p_qb;
    case (phase)
      PH_P: begin
        alu_a1  = u_qa;
        alu_b1  = u_qb;
        alu_old = p_qa;
        alu_c1  = coef_x;
      end
      PH_U: begin
        alu_old = u_qa;
        alu_c1  = coef_x;
      end
      default: begin
        alu_old = v_qa;
        alu_c1  = coef_y;
      end
    endcase
  end

  fdtd_ram #(.WIDTH(VAL_W), .DEPTH(P_DEPTH)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
    .raddr_a(p_ra), .raddr_b(p_rb), .rdata_a(p_qa), .rdata_b(p_qb)
  );

  fdtd_ram #(.WIDTH(VAL_W), .DEPTH(U_DEPTH)) u_u_ram (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd),
    .raddr_a(u_ra), .raddr_b(u_rb), .rdata_a(u_qa), .rdata_b(u_qb)
  );

  fdtd_ram #(.WIDTH(VAL_W), .DEPTH(V_DEPTH)) u_v_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd),
    .raddr_a(v_ra), .raddr_b(v_rb), .rdata_a(v_qa), .rdata_b(v_qb)
  );

  fdtd_alu u_alu (
    .clk(clk), .rst(rst), .ctl(alu_ctl),
    .a1(alu_a1), .b1(alu_b1), .a2(alu_a2), .b2(alu_b2), .old(alu_old),
    .coef1(alu_c1), .coef2(alu_c2), .result(alu_res), .clipped(alu_clip)
  );

  // Result capture: error flag at transfer, read data in the read-wait state
  always_ff @(posedge clk) begin
    if (acc) begin
      res_rv  <= '0;
      res_err <= (func_t'(req.func) == FN_WRITE || func_t'(req.func) == FN_READ) && !idx_ok;
    end
    if (state == ST_RDW) begin
      case (sel_r)
        SEL_P:   res_rv <= p_qa;
        SEL_U:   res_rv <= u_qa;
        default: res_rv <= v_qa;
      endcase
    end
  end

  // Output register; drop valid once taken, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_rv  <= res_rv;
      out_err <= res_err;
      out_sat <= (func_t'(func_r) == FN_STEP) && alu_clip;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_rv;
  assign rsp.saturated   = out_sat;
  assign rsp.index_error = out_err;

endmodule

// ----- src/fdtd_chk.sv -----
// ----------------------------------------------------------------------------
// fdtd_chk
// Port-level checks of the FDTD grid engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdtd_chk (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic saturated,
  input logic index_error
);

  // A stalled response stays offered.
  `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

  // Reset leaves no response pending.
  `ASSERT_CLK_ALWAYS(a_rst_empty, rst |=> !rsp_valid)

  // Only a step clips and only a cell access faults, never both.
  `ASSERT_CLK(a_flags_excl, rsp_valid |-> !(saturated && index_error))

  // A request transfer is followed by a busy state with ready low.
  `ASSERT_CLK(a_busy_after, req_valid && req_ready |=> !req_ready)

endmodule

bind acoustic_fdtd_leapfrog_step fdtd_chk u_fdtd_chk (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .saturated(rsp.saturated),
  .index_error(rsp.index_error)
);

// ----- tb/fdtd_tb_if.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fdtd_tb_if
// Result record shared by the testbench; the channel interfaces come from
// the RTL.
// ----------------------------------------------------------------------------
package fdtd_tb_pkg;
  import fdtd_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic                    saturated;
    logic                    index_error;
  } grid_result_t;
endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the FDTD grid engine against a cell-accurate software grid: cell
// writes and reads, leapfrog steps with saturation, and boundary zeroing,
// under several grid sizes and coefficients with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import fdtd_pkg::*;
  import fdtd_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  fdtd_req_if req ();
  fdtd_rsp_if rsp ();

  acoustic_fdtd_leapfrog_step dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Software copy of the three grids and the four registers.
  longint pres[P_DEPTH];
  longint xvel[U_DEPTH];
  longint yvel[V_DEPTH];
  logic [IDX_W-1:0]  nx_reg, ny_reg;
  logic [COEF_W-1:0] cx_reg, cy_reg;
  bit clip_seen;

  grid_result_t pending_results[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_steps = 0, n_clipped = 0;
  int stall_left = 0;
  bit rsp_idle = 1'b0;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  function automatic longint clip(longint x);
    if (x > VMAX) begin
      clip_seen = 1'b1;
      return VMAX;
    end
    if (x < VMIN) begin
      clip_seen = 1'b1;
      return VMIN;
    end
    return x;
  endfunction

  // Round half up with a floor shift: (coef*diff + 2^15) >>> 16.
  function automatic longint scaled(longint diff, logic [COEF_W-1:0] coef);
    longint prod;
    prod = diff * longint'(coef) + 32768;
    return prod >>> 16;
  endfunction

  function automatic int used_nx();
    if (nx_reg == 0) return 1;
    return (nx_reg > MAX_NX) ? MAX_NX : int'(nx_reg);
  endfunction

  function automatic int used_ny();
    if (ny_reg == 0) return 1;
    return (ny_reg > MAX_NY) ? MAX_NY : int'(ny_reg);
  endfunction

  function automatic void advance_grid();
    int nx, ny;
    longint tx, ty;
    nx = used_nx();
    ny = used_ny();
    for (int i = 0; i < nx; i++)
      for (int j = 0; j < ny; j++) begin
        tx = scaled(clip(xvel[j*U_STRIDE+i+1] - xvel[j*U_STRIDE+i]), cx_reg);
        ty = scaled(clip(yvel[(j+1)*MAX_NX+i] - yvel[j*MAX_NX+i]), cy_reg);
        pres[j*MAX_NX+i] = clip(clip(pres[j*MAX_NX+i] + tx) + ty);
      end
    for (int i = 1; i < nx; i++)
      for (int j = 0; j < ny; j++) begin
        tx = scaled(clip(pres[j*MAX_NX+i] - pres[j*MAX_NX+i-1]), cx_reg);
        xvel[j*U_STRIDE+i] = clip(xvel[j*U_STRIDE+i] + tx);
      end
    for (int i = 0; i < nx; i++)
      for (int j = 1; j < ny; j++) begin
        ty = scaled(clip(pres[j*MAX_NX+i] - pres[(j-1)*MAX_NX+i]), cy_reg);
        yvel[j*MAX_NX+i] = clip(yvel[j*MAX_NX+i] + ty);
      end
  endfunction

  // Work out the result of one request and update the software grid.
  function automatic grid_result_t apply_request(func_t fn, logic [SEL_W-1:0] sel,
      logic [IDX_W-1:0] c, logic [IDX_W-1:0] r, logic signed [VAL_W-1:0] wv);
    grid_result_t res;
    int nx, ny;
    bit ok;
    nx = used_nx();
    ny = used_ny();
    res.read_value = '0;
    res.saturated = 1'b0;
    res.index_error = 1'b0;
    case (fn)
      FN_WRITE, FN_READ: begin
        ok = (sel == SEL_P && c < nx && r < ny) || (sel == SEL_U && c <= nx && r < ny)
          || (sel == SEL_V && c < nx && r <= ny);
        if (!ok) begin
          res.index_error = 1'b1;
        end else if (fn == FN_WRITE) begin
          if (sel == SEL_P) pres[r*MAX_NX+c] = longint'(wv);
          else if (sel == SEL_U) xvel[r*U_STRIDE+c] = longint'(wv);
          else yvel[r*MAX_NX+c] = longint'(wv);
        end else begin
          if (sel == SEL_P) res.read_value = VAL_W'(pres[r*MAX_NX+c]);
          else if (sel == SEL_U) res.read_value = VAL_W'(xvel[r*U_STRIDE+c]);
          else res.read_value = VAL_W'(yvel[r*MAX_NX+c]);
        end
      end
      FN_STEP: begin
        clip_seen = 1'b0;
        advance_grid();
        res.saturated = clip_seen;
        n_steps++;
        if (clip_seen) n_clipped++;
      end
      default: begin
        for (int i = 0; i < nx; i++) begin
          yvel[i] = 0;
          yvel[ny*MAX_NX+i] = 0;
        end
        for (int j = 0; j < ny; j++) begin
          xvel[j*U_STRIDE] = 0;
          xvel[j*U_STRIDE+nx] = 0;
        end
      end
    endcase
    return res;
  endfunction

  // Half the time no gap, else mostly a short one, now and then a long one.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(func_t fn, logic [SEL_W-1:0] sel, logic [IDX_W-1:0] c,
      logic [IDX_W-1:0] r, logic signed [VAL_W-1:0] wv);
    int g;
    g = gap_len();
    // Keep valid high only when the next transfer follows back to back.
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func <= fn;
    req.array_sel <= sel;
    req.col <= c;
    req.row <= r;
    req.write_value <= wv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending_results.push_back(apply_request(fn, sel, c, r, wv));
    n_sent++;
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CELLS_X: nx_reg = val[IDX_W-1:0];
      REG_CELLS_Y: ny_reg = val[IDX_W-1:0];
      REG_COEF_X:  cx_reg = val;
      default:     cy_reg = val;
    endcase
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_grid(int nx, int ny, int cx, int cy);
    drain();
    write_reg(REG_CELLS_X, CFG_DW'(nx));
    write_reg(REG_CELLS_Y, CFG_DW'(ny));
    write_reg(REG_COEF_X, CFG_DW'(cx));
    write_reg(REG_COEF_Y, CFG_DW'(cy));
  endtask

  // Response side: random stalls, check each transfer against the oldest expectation.
  always @(posedge clk) begin
    grid_result_t exp_res;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        n_checked++;
        if (rsp.read_value !== exp_res.read_value) begin
          $error("read_value expected %0d got %0d", exp_res.read_value, rsp.read_value);
          errors++;
        end
        if (rsp.saturated !== exp_res.saturated) begin
          $error("saturated expected %0b got %0b", exp_res.saturated, rsp.saturated);
          errors++;
        end
        if (rsp.index_error !== exp_res.index_error) begin
          $error("index_error expected %0b got %0b", exp_res.index_error,
                 rsp.index_error);
          errors++;
        end
      end
    end
    if (rsp_idle) begin
      rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else begin
      stall_left = gap_len();
      if (stall_left == 0) begin
        rsp.ready <= 1'b1;
      end else begin
        stall_left--;
        rsp.ready <= 1'b0;
      end
    end
  end

  task automatic test_cell_access();
    set_grid(3, 2, 32768, 32768);
    send_request(FN_WRITE, SEL_P, 0, 0, 32'sh7FFF_FFFF);
    send_request(FN_WRITE, SEL_P, 2, 1, 32'sh8000_0000);
    send_request(FN_WRITE, SEL_U, 3, 1, 32'sh0001_0000);
    send_request(FN_WRITE, SEL_V, 2, 2, -32'sd65536);
    send_request(FN_READ, SEL_P, 0, 0, 0);
    send_request(FN_READ, SEL_P, 2, 1, 32'shFFFF_FFFF);
    send_request(FN_READ, SEL_U, 3, 1, 0);
    send_request(FN_READ, SEL_V, 2, 2, 0);
    // Out of range indexes and the missing fourth array.
    send_request(FN_WRITE, SEL_P, 3, 0, 5);
    send_request(FN_READ, SEL_U, 4, 0, 0);
    send_request(FN_READ, SEL_V, 0, 3, 0);
    send_request(FN_WRITE, 2'd3, 0, 0, 7);
    send_request(FN_READ, 2'd3, 0, 0, 0);
    send_request(FN_READ, SEL_P, 7'h7F, 7'h7F, 0);
  endtask

  task automatic test_step_and_zero();
    // Extreme values from the cell test feed the steps; the saturation flag is checked.
    send_request(FN_STEP, 2'd3, 7'h7F, 7'h7F, 32'shFFFF_FFFF);
    send_request(FN_READ, SEL_P, 1, 0, 0);
    send_request(FN_READ, SEL_U, 1, 1, 0);
    send_request(FN_ZERO, SEL_V, 5, 5, 1);
    send_request(FN_READ, SEL_U, 3, 1, 0);
    send_request(FN_STEP, SEL_P, 0, 0, 0);
    send_request(FN_READ, SEL_V, 1, 1, 0);
  endtask

  task automatic test_count_limits();
    // Zero counts act as one; counts above the maximum act as the maximum.
    set_grid(0, 0, 0, 65535);
    send_request(FN_READ, SEL_U, 1, 0, 0);
    send_request(FN_READ, SEL_P, 1, 0, 0);
    send_request(FN_STEP, SEL_P, 0, 0, 0);
    set_grid(127, 2, 65535, 0);
    send_request(FN_READ, SEL_U, 64, 1, 0);
    send_request(FN_WRITE, SEL_U, 64, 0, 32'sh1234_5678);
    send_request(FN_STEP, SEL_P, 0, 0, 0);
  endtask

  task automatic test_random_traffic();
    int nx, ny, k;
    logic [SEL_W-1:0] sel;
    logic signed [VAL_W-1:0] wv;
    for (int phase = 0; phase < 4; phase++) begin
      set_grid($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 65535),
               $urandom_range(0, 65535));
      nx = used_nx();
      ny = used_ny();
      for (int n = 0; n < 15; n++) begin
        k = $urandom_range(0, 99);
        sel = (k % 17 == 0) ? 2'd3 : SEL_W'($urandom_range(0, 2));
        wv = (k % 5 == 0) ? $urandom : $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
        if (k < 45)
          send_request(FN_WRITE, sel, IDX_W'($urandom_range(0, nx + 1)),
                       IDX_W'($urandom_range(0, ny + 1)), wv);
        else if (k < 80)
          send_request(FN_READ, sel, IDX_W'($urandom_range(0, nx + 1)),
                       IDX_W'($urandom_range(0, ny + 1)), wv);
        else if (k < 93)
          send_request(FN_STEP, SEL_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                       VAL_W'($urandom));
        else
          send_request(FN_ZERO, SEL_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                       VAL_W'($urandom));
      end
      // Read the first row of x-velocities so step effects reach the checker.
      for (int i = 0; i <= nx; i++) send_request(FN_READ, SEL_U, IDX_W'(i), 0, 0);
    end
    // One full-size step at the default grid.
    set_grid(64, 64, 32768, 32768);
    send_request(FN_WRITE, SEL_P, 63, 63, VAL_W'($urandom));
    send_request(FN_STEP, SEL_P, 0, 0, 0);
    send_request(FN_READ, SEL_U, 63, 63, 0);
    send_request(FN_READ, SEL_V, 63, 63, 0);
  endtask

  initial begin
    nx_reg = CELLS_RST;
    ny_reg = CELLS_RST;
    cx_reg = COEF_RST;
    cy_reg = COEF_RST;
    for (int i = 0; i < P_DEPTH; i++) pres[i] = 0;
    for (int i = 0; i < U_DEPTH; i++) xvel[i] = 0;
    for (int i = 0; i < V_DEPTH; i++) yvel[i] = 0;
    req.valid = 1'b0;
    req.func = FN_WRITE;
    req.array_sel = SEL_P;
    req.col = '0;
    req.row = '0;
    req.write_value = '0;
    rsp.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_cell_access();
    test_step_and_zero();
    test_count_limits();
    test_random_traffic();
    rsp_idle = 1'b1;
    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests, %0d results checked, %0d steps (%0d clipped).",
             n_sent, n_checked, n_steps, n_clipped);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[acoustic_fdtd_leapfrog_step] OK");
    end else begin
      $display("[acoustic_fdtd_leapfrog_step] ERROR");
    end
    $finish;
  end

  // Watchdog: a few full-size steps plus clearing and idling, with wide margin.
  initial begin
    #(20ns * 3000000);
    $display("[acoustic_fdtd_leapfrog_step] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/fdtd_pkg.sv
src/fdtd_if.sv
src/fdtd_ram.sv
src/fdtd_alu.sv
src/acoustic_fdtd_leapfrog_step.sv
src/fdtd_chk.sv
tb/fdtd_tb_if.sv
tb/testbench.sv
